/* rtl/core/bxd_pkg.sv */
`default_nettype none

package bxd_pkg;

  localparam int PIX_W      = 8;
  localparam int ACC_W      = 16;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_FACTOR = 16;
  localparam int MAX_HEIGHT = 1024;
  localparam int ACC_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(ACC_DEPTH);
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int SUB_W      = $clog2(MAX_FACTOR);
  localparam int THUMB_W    = 9;

  localparam int FACTOR_W   = 5;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int DIVD_W     = 16;
  localparam int DIVR_W     = 9;
  localparam int DCNT_W     = 5;

  localparam logic [DCNT_W-1:0] DIV_STEPS_FULL  = DCNT_W'(DIVD_W);
  localparam logic [DCNT_W-1:0] DIV_STEPS_SHORT = DCNT_W'(PIX_W);

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic              start;
    logic              short_mode;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIVD_W-1:0] quot;
    logic [DIVR_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/bxd_ifs.sv */
`default_nettype none

interface bxd_in_if;
  import bxd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface bxd_out_if;
  import bxd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   thumb_pixel;
  logic [THUMB_W-1:0] thumb_col;
  logic [THUMB_W-1:0] thumb_row;
  logic               frame_last;
  modport source (output valid, output thumb_pixel, output thumb_col, output thumb_row,
                  output frame_last, input ready);
  modport sink   (input valid, input thumb_pixel, input thumb_col, input thumb_row,
                  input frame_last, output ready);
endinterface

interface bxd_cfg_if;
  import bxd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/bxd_ram.sv */
`default_nettype none

module bxd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bxd_div.sv */
`default_nettype none

module bxd_div
  import bxd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVD_W-1:0] sh_r;
  logic [DIVR_W-1:0] dsr_r;

  logic [DIVR_W:0]   trial;
  logic              ge;
  logic [DIVR_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, sh_r[DIVD_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? DIVR_W'(trial - {1'b0, dsr_r}) : trial[DIVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.short_mode ? DIV_STEPS_SHORT : DIV_STEPS_FULL;
    end else if (busy_r) begin
      busy_r <= cnt_r != DCNT_W'(1);
      cnt_r  <= cnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr_r <= req.divisor;
      if (req.short_mode) begin
        rem_r <= DIVR_W'(req.dividend[DIVD_W-1:PIX_W]);
        sh_r  <= {req.dividend[PIX_W-1:0], {(DIVD_W-PIX_W){1'b0}}};
      end else begin
        rem_r <= '0;
        sh_r  <= req.dividend;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[DIVD_W-2:0], ge};
    end
  end

  assign rsp = '{busy: busy_r, quot: sh_r, rem: rem_r};

endmodule

`default_nettype wire

/* rtl/core/box_average_downscaler_unit.sv */
// Box-average downscaler: sums each factor x factor block of a grey image and
// emits the truncated block average with its thumbnail row and column.
// in_ch  : source pixels in raster order; frame_start marks pixel (0,0).
// out_ch : one item per completed block; frame_last on the frame's last one.
// cfg_ch : register writes (0 factor, 1 width, 2 height), always ready.
// Flow   : a pixel outside any whole block is accepted in the idle state; a
//   pixel inside a block also takes an accumulator RAM read, then write-back.
//   A block's last pixel adds a check state, an 8-step divider pass and its
//   result state when the average does not saturate, and a state that loads
//   the output register.
// After the last of a run of register writes the block count, row count and
//   current block row are recomputed by the shared divider (in_ch not ready).
// Reset restores factor 2, 64 x 64 source; accumulators are not cleared, a
//   block's first pixel overwrites its entry.
// A stalled receiver holds the output register; one more pixel stream may
//   proceed until the next result needs the register.
`default_nettype none

module box_average_downscaler_unit
  import bxd_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst_n,
  bxd_in_if.sink     in_ch,
  bxd_out_if.source  out_ch,
  bxd_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RMW  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_CFG0 = 4'd5;
  localparam logic [3:0] S_CFGW = 4'd6;
  localparam logic [3:0] S_CFGH = 4'd7;
  localparam logic [3:0] S_CFGR = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [FACTOR_W-1:0] factor_r;
  logic [SIZE_W-1:0]   width_r;
  logic [SIZE_W-1:0]   height_r;
  logic [FACTOR_W-1:0] f_c;
  logic [SIZE_W-1:0]   w_c;
  logic [SIZE_W-1:0]   h_c;
  logic [2*FACTOR_W-1:0] ff_full;
  logic [DIVR_W-1:0]   ff;

  logic [POS_W-1:0] nbc_r, nbr_r;
  logic [POS_W-1:0] scol_r, srow_r, bcol_r, brow_r;
  logic [SUB_W-1:0] subc_r, subr_r, rrem_r;

  logic [POS_W-1:0] c_scol, c_srow, c_bcol, c_brow;
  logic [SUB_W-1:0] c_subc, c_subr, c_rrem;
  logic [POS_W-1:0] scol_nxt, srow_nxt, bcol_nxt, brow_nxt;
  logic [SUB_W-1:0] subc_nxt, subr_nxt, rrem_nxt;
  logic [POS_W:0]   scol_inc, srow_inc;
  logic             last_c, last_r, active, emit, first, flast;

  logic               in_acc, cfg_acc;
  logic [PIX_W-1:0]   pix_r;
  logic               first_r, emit_r, flast_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [THUMB_W-1:0] col_r, row_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc;
  logic [PIX_W-1:0]   avg_r;
  logic               sat;

  logic               out_valid_r;
  logic [PIX_W-1:0]   opix_r;
  logic [THUMB_W-1:0] ocol_r, orow_r;
  logic               olast_r;
  logic               out_load;

  logic [ACC_W-1:0] ram_rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;

  // clamped configuration
  always_comb begin
    if (factor_r < FACTOR_W'(2))               f_c = FACTOR_W'(2);
    else if (factor_r > FACTOR_W'(MAX_FACTOR)) f_c = FACTOR_W'(MAX_FACTOR);
    else                                       f_c = factor_r;
    if (width_r < SIZE_W'(2))                  w_c = SIZE_W'(2);
    else if (width_r > SIZE_W'(MAX_WIDTH))     w_c = SIZE_W'(MAX_WIDTH);
    else                                       w_c = width_r;
    if (height_r < SIZE_W'(2))                 h_c = SIZE_W'(2);
    else if (height_r > SIZE_W'(MAX_HEIGHT))   h_c = SIZE_W'(MAX_HEIGHT);
    else                                       h_c = height_r;
    ff_full = f_c * f_c;
    ff      = ff_full[DIVR_W-1:0];
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;

  // position of the incoming item and the counters after it
  always_comb begin
    if (in_ch.frame_start) begin
      c_scol = '0; c_srow = '0; c_bcol = '0; c_brow = '0;
      c_subc = '0; c_subr = '0; c_rrem = '0;
    end else begin
      c_scol = scol_r; c_srow = srow_r; c_bcol = bcol_r; c_brow = brow_r;
      c_subc = subc_r; c_subr = subr_r; c_rrem = rrem_r;
    end

    last_c = {1'b0, c_subc} >= (f_c - FACTOR_W'(1));
    last_r = {1'b0, c_subr} >= (f_c - FACTOR_W'(1));
    active = (c_bcol < nbc_r) && !c_bcol[POS_W-1] && (c_brow < nbr_r);
    emit   = active && last_c && last_r;
    first  = (c_subc == '0) && (c_subr == '0);
    flast  = (c_bcol == nbc_r - POS_W'(1)) && (c_brow == nbr_r - POS_W'(1));

    scol_inc = {1'b0, c_scol} + (POS_W+1)'(1);
    srow_inc = {1'b0, c_srow} + (POS_W+1)'(1);

    scol_nxt = scol_inc[POS_W-1:0];
    srow_nxt = c_srow;
    bcol_nxt = c_bcol;
    brow_nxt = c_brow;
    subc_nxt = c_subc;
    subr_nxt = c_subr;
    rrem_nxt = c_rrem;

    if (last_c) begin
      subc_nxt = '0;
      if (c_bcol < nbc_r) begin
        bcol_nxt = c_bcol + POS_W'(1);
      end
    end else begin
      subc_nxt = c_subc + SUB_W'(1);
    end

    if (scol_inc >= (POS_W+1)'(w_c)) begin
      scol_nxt = '0;
      subc_nxt = '0;
      bcol_nxt = '0;
      srow_nxt = srow_inc[POS_W-1:0];
      subr_nxt = last_r ? '0 : c_subr + SUB_W'(1);
      if (({1'b0, c_rrem} + FACTOR_W'(1)) == f_c) begin
        rrem_nxt = '0;
        brow_nxt = c_brow + POS_W'(1);
      end else begin
        rrem_nxt = c_rrem + SUB_W'(1);
      end
      if (srow_inc >= (POS_W+1)'(h_c)) begin
        srow_nxt = '0;
        subr_nxt = '0;
        brow_nxt = '0;
        rrem_nxt = '0;
      end
    end
  end

  // sums clip at full scale; a clipped block still averages to 255
  assign acc_sum = first_r ? (ACC_W+1)'(pix_r) : {1'b0, ram_rdata} + (ACC_W+1)'(pix_r);
  assign acc     = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
  assign sat     = {1'b0, acc_r} >= {ff, {PIX_W{1'b0}}};

  bxd_ram #(
    .WIDTH(ACC_W),
    .DEPTH(ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (state_r == S_RMW),
    .waddr (addr_r),
    .wdata (acc),
    .re    (in_acc),
    .raddr (c_bcol[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    dreq = '0;
    unique case (state_r)
      S_CFG0: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIVD_W'(w_c);
        dreq.divisor  = DIVR_W'(f_c);
      end
      S_CFGW: begin
        dreq.start    = !drsp.busy;
        dreq.dividend = DIVD_W'(h_c);
        dreq.divisor  = DIVR_W'(f_c);
      end
      S_CFGH: begin
        dreq.start    = !drsp.busy;
        dreq.dividend = DIVD_W'(srow_r);
        dreq.divisor  = DIVR_W'(f_c);
      end
      S_CHK: begin
        dreq.start      = !sat;
        dreq.short_mode = 1'b1;
        dreq.dividend   = acc_r;
        dreq.divisor    = ff;
      end
      default: dreq = '0;
    endcase
  end

  bxd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    priority if (cfg_acc) begin
      state_nxt = S_CFG0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_acc && active) state_nxt = S_RMW;
        S_RMW:  state_nxt = emit_r ? S_CHK : S_IDLE;
        S_CHK:  state_nxt = sat ? S_OUT : S_DIV;
        S_DIV:  if (!drsp.busy) state_nxt = S_OUT;
        S_OUT:  if (out_load) state_nxt = S_IDLE;
        S_CFG0: state_nxt = S_CFGW;
        S_CFGW: if (!drsp.busy) state_nxt = S_CFGH;
        S_CFGH: if (!drsp.busy) state_nxt = S_CFGR;
        S_CFGR: if (!drsp.busy) state_nxt = S_IDLE;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      factor_r <= FACTOR_W'(2);
      width_r  <= SIZE_W'(64);
      height_r <= SIZE_W'(64);
      nbc_r    <= POS_W'(32);
      nbr_r    <= POS_W'(32);
      scol_r   <= '0;
      srow_r   <= '0;
      bcol_r   <= '0;
      brow_r   <= '0;
      subc_r   <= '0;
      subr_r   <= '0;
      rrem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_ch.reg_index)
          REG_FACTOR: factor_r <= cfg_ch.wdata[FACTOR_W-1:0];
          REG_WIDTH:  width_r  <= cfg_ch.wdata[SIZE_W-1:0];
          REG_HEIGHT: height_r <= cfg_ch.wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        scol_r <= scol_nxt;
        srow_r <= srow_nxt;
        bcol_r <= bcol_nxt;
        brow_r <= brow_nxt;
        subc_r <= subc_nxt;
        subr_r <= subr_nxt;
        rrem_r <= rrem_nxt;
      end
      if (!cfg_acc && !drsp.busy) begin
        if (state_r == S_CFGW) nbc_r <= drsp.quot[POS_W-1:0];
        if (state_r == S_CFGH) nbr_r <= drsp.quot[POS_W-1:0];
        if (state_r == S_CFGR) begin
          brow_r <= drsp.quot[POS_W-1:0];
          rrem_r <= drsp.rem[SUB_W-1:0];
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r   <= in_ch.pixel_in;
      first_r <= first;
      emit_r  <= emit;
      flast_r <= flast;
      addr_r  <= c_bcol[ADDR_W-1:0];
      col_r   <= c_bcol[THUMB_W-1:0];
      row_r   <= c_brow[THUMB_W-1:0];
    end
    if (state_r == S_RMW) begin
      acc_r <= acc;
    end
    if (state_r == S_CHK && sat) begin
      avg_r <= {PIX_W{1'b1}};
    end else if (state_r == S_DIV && !drsp.busy) begin
      avg_r <= drsp.quot[PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      opix_r  <= avg_r;
      ocol_r  <= col_r;
      orow_r  <= row_r;
      olast_r <= flast_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.thumb_pixel = opix_r;
  assign out_ch.thumb_col   = ocol_r;
  assign out_ch.thumb_row   = orow_r;
  assign out_ch.frame_last  = olast_r;

endmodule

`default_nettype wire
